@@ hdl/marker_pose_to_velocity_command_unit_defines.svh @@
// Assertion macros shared by the marker pose to velocity command unit
`ifndef MARKER_POSE_TO_VELOCITY_COMMAND_UNIT_DEFINES_SVH
`define MARKER_POSE_TO_VELOCITY_COMMAND_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MPV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MPV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPV_ASSERT(lbl, clk, rst, prop, msg)
`define MPV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/mpv_pkg.sv @@
// Shared types, constants and the arctangent table for the pose to velocity unit
`default_nettype none
package mpv_pkg;

   localparam int CNT_W        = 5;
   localparam int CORDIC_STEPS = 17;
   localparam int DIV_STEPS    = 13;
   localparam int ANG_W        = 20;
   localparam int QW           = 13;
   localparam int REL_W        = 14;

   localparam logic [QW-1:0]           Q12_ONE     = QW'(4096);
   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = ANG_W'(102944);

   localparam logic [2:0] REG_TIMEOUT     = 3'd0;
   localparam logic [2:0] REG_SPEED_SCALE = 3'd1;
   localparam logic [2:0] REG_MAX_ANGLE   = 3'd2;
   localparam logic [2:0] REG_MAX_LIN     = 3'd3;
   localparam logic [2:0] REG_MAX_ANGSTEP = 3'd4;

   localparam logic [31:0] TIMEOUT_RST     = 32'd5000;
   localparam logic [15:0] SPEED_SCALE_RST = 16'd256;
   localparam logic [12:0] MAX_ANGLE_RST   = 13'd1571;
   localparam logic [14:0] MAX_LIN_RST     = 15'd901;
   localparam logic [14:0] MAX_ANGSTEP_RST = 15'd11633;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MISS, ST_SQX, ST_SQY, ST_SQSUM, ST_SQRT, ST_CORDIC, ST_DECIDE,
      ST_LMUL, ST_LDIVI, ST_LDIV, ST_AMUL, ST_ADIVI, ST_ADIV, ST_VLIN, ST_VANG,
      ST_EMIT
   } mpv_state_type;

   typedef struct packed {
      mpv_state_type    state;
      logic [CNT_W-1:0] cnt;
      logic             take;
   } mpv_ctl_type;

   typedef struct packed {
      logic ref_valid;
      logic out_free;
   } mpv_sts_type;

   // atan(2^-i) in Q16 radians
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = ANG_W'(51472);
         5'd1:    v = ANG_W'(30386);
         5'd2:    v = ANG_W'(16055);
         5'd3:    v = ANG_W'(8150);
         5'd4:    v = ANG_W'(4091);
         5'd5:    v = ANG_W'(2047);
         5'd6:    v = ANG_W'(1024);
         5'd7:    v = ANG_W'(512);
         5'd8:    v = ANG_W'(256);
         5'd9:    v = ANG_W'(128);
         5'd10:   v = ANG_W'(64);
         5'd11:   v = ANG_W'(32);
         5'd12:   v = ANG_W'(16);
         5'd13:   v = ANG_W'(8);
         5'd14:   v = ANG_W'(4);
         5'd15:   v = ANG_W'(2);
         5'd16:   v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hdl/marker_pose_to_velocity_command_unit.sv @@
// Top level of the marker pose to velocity command unit
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    found, four corners, time_ms
//   rsp      out        rsp_valid/rsp_ready    linear/angular velocity, is_stop
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A sighting runs on the shared datapath: one digit per cycle through the root,
// 17 CORDIC steps and two 13-step divisions.
// A first sighting ends after the CORDIC; a miss with a reference yields a stop command.
// Reset restores register defaults and drops the reference; no clearing pass.
// A held result stalls only the final transfer; req_ready is low while a frame is in work.
`default_nettype none
module marker_pose_to_velocity_command_unit #(
   parameter int COORD_BITS = 16,
   parameter int VEL_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_found,
   input  logic [COORD_BITS-1:0]      req_corner0_x,
   input  logic [COORD_BITS-1:0]      req_corner0_y,
   input  logic [COORD_BITS-1:0]      req_corner1_x,
   input  logic [COORD_BITS-1:0]      req_corner1_y,
   input  logic [COORD_BITS-1:0]      req_corner2_x,
   input  logic [COORD_BITS-1:0]      req_corner2_y,
   input  logic [COORD_BITS-1:0]      req_corner3_x,
   input  logic [COORD_BITS-1:0]      req_corner3_y,
   input  logic [31:0]                req_time_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VEL_BITS-1:0] rsp_linear_velocity,
   output logic signed [VEL_BITS-1:0] rsp_angular_velocity,
   output logic                       rsp_is_stop,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data
);
   import mpv_pkg::*;

   mpv_ctl_type ctl;
   mpv_sts_type sts;
   logic        csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   mpv_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_found (req_found),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   mpv_datapath #(
      .COORD_BITS (COORD_BITS),
      .VEL_BITS   (VEL_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .sts                  (sts),
      .req_corner0_x        (req_corner0_x),
      .req_corner0_y        (req_corner0_y),
      .req_corner1_x        (req_corner1_x),
      .req_corner1_y        (req_corner1_y),
      .req_corner2_x        (req_corner2_x),
      .req_corner2_y        (req_corner2_y),
      .req_corner3_x        (req_corner3_x),
      .req_corner3_y        (req_corner3_y),
      .req_time_ms          (req_time_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_is_stop          (rsp_is_stop),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

endmodule
`default_nettype wire

@@ hdl/mpv_ctrl.sv @@
// Sequencer for the pose to velocity unit: steps the shared datapath through each frame
`default_nettype none
`include "marker_pose_to_velocity_command_unit_defines.svh"
module mpv_ctrl #(
   parameter int COORD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_found,
   output logic                 req_ready,
   input  mpv_pkg::mpv_sts_type sts,
   output mpv_pkg::mpv_ctl_type ctl
);
   import mpv_pkg::*;

   localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(COORD_BITS + 6);
   localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

   mpv_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take;

   assign take = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_found) state_in = ST_SQX;
               else if (sts.ref_valid) state_in = ST_MISS;
            end
         end
         ST_MISS:   if (sts.out_free) state_in = ST_IDLE;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_SQSUM;
         ST_SQSUM:  state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == SQRT_LAST) state_in = ST_CORDIC;
         ST_CORDIC: if (cnt_ff == CORDIC_LAST) state_in = ST_DECIDE;
         ST_DECIDE: state_in = sts.ref_valid ? ST_LMUL : ST_IDLE;
         ST_LMUL:   state_in = ST_LDIVI;
         ST_LDIVI:  state_in = ST_LDIV;
         ST_LDIV:   if (cnt_ff == DIV_LAST) state_in = ST_AMUL;
         ST_AMUL:   state_in = ST_ADIVI;
         ST_ADIVI:  state_in = ST_ADIV;
         ST_ADIV:   if (cnt_ff == DIV_LAST) state_in = ST_VLIN;
         ST_VLIN:   state_in = ST_VANG;
         ST_VANG:   state_in = ST_EMIT;
         ST_EMIT:   if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // iteration count restarts on every state change
   assign cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      ctl.state = state_ff;
      ctl.cnt   = cnt_ff;
      ctl.take  = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `MPV_ASSERT(a_found_starts, clock, reset, take && req_found |=> state_ff == ST_SQX, "found frame did not start the square stage")
   `MPV_ASSERT(a_sqrt_cnt, clock, reset, !(state_ff == ST_SQRT && cnt_ff > SQRT_LAST), "square root ran past its last digit")
   `MPV_ASSERT(a_miss_ref, clock, reset, state_ff == ST_MISS |-> sts.ref_valid, "stop command without a reference")

endmodule
`default_nettype wire

@@ hdl/mpv_datapath.sv @@
// Shared datapath: multiplier, square root, CORDIC, divider, config and result registers
`default_nettype none
`include "marker_pose_to_velocity_command_unit_defines.svh"
module mpv_datapath #(
   parameter int COORD_BITS = 16,
   parameter int VEL_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mpv_pkg::mpv_ctl_type        ctl,
   output mpv_pkg::mpv_sts_type        sts,
   input  logic [COORD_BITS-1:0]       req_corner0_x,
   input  logic [COORD_BITS-1:0]       req_corner0_y,
   input  logic [COORD_BITS-1:0]       req_corner1_x,
   input  logic [COORD_BITS-1:0]       req_corner1_y,
   input  logic [COORD_BITS-1:0]       req_corner2_x,
   input  logic [COORD_BITS-1:0]       req_corner2_y,
   input  logic [COORD_BITS-1:0]       req_corner3_x,
   input  logic [COORD_BITS-1:0]       req_corner3_y,
   input  logic [31:0]                 req_time_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VEL_BITS-1:0]  rsp_linear_velocity,
   output logic signed [VEL_BITS-1:0]  rsp_angular_velocity,
   output logic                        rsp_is_stop,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_data
);
   import mpv_pkg::*;

   localparam int VXW  = COORD_BITS + 3;
   localparam int RW   = VXW + 4;
   localparam int NW   = 2 * RW;
   localparam int MW   = (RW + 1 > 22) ? RW + 1 : 22;
   localparam int PW   = 2 * MW;
   localparam int XW   = VXW + 18;
   localparam int DENW = (RW > 13) ? RW : 13;
   localparam int DSW  = DENW + 13;
   localparam int DNW  = RW + 22;
   localparam int EW   = (VEL_BITS > 18) ? VEL_BITS : 18;
   localparam logic [63:0] VMAX64 = (64'd1 << (VEL_BITS - 1)) - 64'd1;
   localparam logic signed [EW-1:0] VMAX_E = EW'(VMAX64);
   localparam logic signed [EW-1:0] VMIN_E = -VMAX_E - EW'(1);

   // configuration
   logic [31:0] timeout_ff;
   logic [15:0] scale_ff;
   logic [12:0] maxang_ff;
   logic [14:0] maxlin_ff;
   logic [14:0] maxangstep_ff;

   // reference and frame
   logic                    ref_valid_ff;
   logic [RW-1:0]           ref_dist_ff;
   logic signed [ANG_W-1:0] ref_ang_ff;
   logic [31:0]             last_hit_ff;
   logic [31:0]             time_ff;
   logic signed [VXW-1:0]   vx_ff, vy_ff;
   logic                    zero_ff;

   // shared multiplier
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod, mul_ff, acc_ff;

   // square root
   logic [NW-1:0]   n_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [RW+3:0]   remx, trialx;
   logic            sq_ge;

   // CORDIC
   logic signed [XW-1:0]    x_ff, y_ff, xs, ys, xe, ye;
   logic signed [ANG_W-1:0] z_ff, ang_ff, tab;

   // divider
   logic [DNW-1:0]       dn_ff, su_mag, su_n;
   logic [DSW-1:0]       dsh_ff, su_dsh;
   logic [DENW-1:0]      su_den;
   logic [QW-1:0]        q_ff, qf;
   logic                 dzero_ff, dclamp_ff, dneg_ff, div_ge;
   logic [PW-1:0]        absprod;
   logic signed [PW-1:0] mr_full;
   logic [14:0]          mrad;
   logic signed [REL_W-1:0] rel_lin_ff, rel_ang_ff, relp;

   // angle difference
   logic signed [ANG_W:0] adiff;
   logic [ANG_W:0]        admag;

   // velocity rounding
   logic [PW-1:0]          vsum;
   logic [16:0]            vmag;
   logic signed [17:0]     vs;
   logic signed [EW-1:0]   ve, vsat;
   logic signed [VEL_BITS-1:0] lin_v_ff;

   // output register
   logic                       rsp_valid_ff, rsp_stop_ff, out_free;
   logic signed [VEL_BITS-1:0] rsp_lin_ff, rsp_ang_ff;

   logic signed [VXW-1:0] vx_new, vy_new;

   assign vx_new = VXW'(req_corner0_x) + VXW'({req_corner0_x, 1'b0}) - VXW'(req_corner1_x)
                 - VXW'(req_corner2_x) - VXW'(req_corner3_x);
   assign vy_new = VXW'(req_corner0_y) + VXW'({req_corner0_y, 1'b0}) - VXW'(req_corner1_y)
                 - VXW'(req_corner2_y) - VXW'(req_corner3_y);

   assign out_free = !rsp_valid_ff || rsp_ready;
   always_comb begin
      sts.ref_valid = ref_valid_ff;
      sts.out_free  = out_free;
   end

   // angle change against the reference, unwrapped
   assign adiff = (ANG_W+1)'(ang_ff) - (ANG_W+1)'(ref_ang_ff);
   assign admag = adiff[ANG_W] ? ANG_W'(0) - adiff : adiff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.state)
         ST_SQX: begin
            mul_a = MW'(vx_ff);
            mul_b = MW'(vx_ff);
         end
         ST_SQY: begin
            mul_a = MW'(vy_ff);
            mul_b = MW'(vy_ff);
         end
         ST_LMUL: begin
            mul_a = MW'($signed({1'b0, root_ff}) - $signed({1'b0, ref_dist_ff}));
            mul_b = MW'($signed({1'b0, scale_ff}));
         end
         ST_AMUL: begin
            mul_a = MW'($signed({1'b0, admag}));
            mul_b = MW'(1000);
         end
         ST_VLIN: begin
            mul_a = MW'(rel_lin_ff);
            mul_b = MW'($signed({1'b0, maxlin_ff}));
         end
         ST_VANG: begin
            mul_a = MW'(rel_ang_ff);
            mul_b = MW'($signed({1'b0, maxangstep_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // one root digit per cycle
   assign remx   = {rem_ff, n_ff[NW-1 -: 2]};
   assign trialx = (RW+4)'({root_ff, 2'b01});
   assign sq_ge  = remx >= trialx;

   // CORDIC rotation
   assign xs  = x_ff >>> ctl.cnt;
   assign ys  = y_ff >>> ctl.cnt;
   assign tab = atan_entry(ctl.cnt);
   assign xe  = XW'(vx_ff) <<< 16;
   assign ye  = XW'(vy_ff) <<< 16;

   // divider setup
   assign absprod = mul_ff[PW-1] ? PW'(0) - mul_ff : mul_ff;
   assign mr_full = (mul_ff + PW'(32768)) >>> 16;
   assign mrad    = mr_full[14:0];
   always_comb begin
      if (ctl.state == ST_LDIVI) begin
         su_mag = DNW'(absprod) << 4;
         su_den = DENW'(ref_dist_ff);
      end else begin
         su_mag = DNW'(mrad) << 12;
         su_den = DENW'(maxang_ff);
      end
      su_n   = (su_mag << 1) + DNW'(su_den);
      su_dsh = DSW'(su_den) << 13;
   end
   assign div_ge = dn_ff >= DNW'(dsh_ff);
   assign qf     = dzero_ff ? '0 : (dclamp_ff ? Q12_ONE : q_ff);
   assign relp   = REL_W'(qf);

   // round to nearest, halves away from zero, then saturate
   assign vsum = (mul_ff[PW-1] ? PW'(0) - mul_ff : mul_ff) + PW'(2048);
   assign vmag = vsum[28:12];
   assign vs   = mul_ff[PW-1] ? 18'sd0 - $signed({1'b0, vmag}) : $signed({1'b0, vmag});
   assign ve   = EW'(vs);
   assign vsat = (ve > VMAX_E) ? VMAX_E : ((ve < VMIN_E) ? VMIN_E : ve);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RST;
         scale_ff      <= SPEED_SCALE_RST;
         maxang_ff     <= MAX_ANGLE_RST;
         maxlin_ff     <= MAX_LIN_RST;
         maxangstep_ff <= MAX_ANGSTEP_RST;
         ref_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TIMEOUT:     timeout_ff    <= csr_data;
               REG_SPEED_SCALE: scale_ff      <= csr_data[15:0];
               REG_MAX_ANGLE:   maxang_ff     <= csr_data[12:0];
               REG_MAX_LIN:     maxlin_ff     <= csr_data[14:0];
               REG_MAX_ANGSTEP: maxangstep_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         if ((ctl.state == ST_MISS || ctl.state == ST_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.state == ST_MISS && out_free && (time_ff - last_hit_ff) > timeout_ff) begin
            ref_valid_ff <= 1'b0;
         end else if (ctl.state == ST_DECIDE) begin
            ref_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.state)
         ST_IDLE: begin
            if (ctl.take) begin
               time_ff <= req_time_ms;
               vx_ff   <= vx_new;
               vy_ff   <= vy_new;
               zero_ff <= (vx_new == '0) && (vy_new == '0);
            end
         end
         ST_MISS: begin
            if (out_free) begin
               rsp_lin_ff  <= '0;
               rsp_ang_ff  <= '0;
               rsp_stop_ff <= 1'b1;
            end
         end
         ST_SQX: mul_ff <= prod;
         ST_SQY: begin
            acc_ff <= mul_ff;
            mul_ff <= prod;
         end
         ST_SQSUM: begin
            n_ff    <= NW'(acc_ff + mul_ff) << 8;
            rem_ff  <= '0;
            root_ff <= '0;
            if (vx_ff < 0) begin
               if (vy_ff >= 0) begin
                  x_ff <= ye;
                  y_ff <= -xe;
                  z_ff <= HALF_PI_Q16;
               end else begin
                  x_ff <= -ye;
                  y_ff <= xe;
                  z_ff <= -HALF_PI_Q16;
               end
            end else begin
               x_ff <= xe;
               y_ff <= ye;
               z_ff <= '0;
            end
         end
         ST_SQRT: begin
            n_ff    <= n_ff << 2;
            rem_ff  <= sq_ge ? (RW+2)'(remx - trialx) : (RW+2)'(remx);
            root_ff <= {root_ff[RW-2:0], sq_ge};
         end
         ST_CORDIC: begin
            if (y_ff > 0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + tab;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - tab;
            end
         end
         ST_DECIDE: begin
            ang_ff      <= zero_ff ? '0 : z_ff;
            last_hit_ff <= time_ff;
            if (!ref_valid_ff) begin
               ref_dist_ff <= root_ff;
               ref_ang_ff  <= zero_ff ? '0 : z_ff;
            end
         end
         ST_LMUL: mul_ff <= prod;
         ST_LDIVI, ST_ADIVI: begin
            if (ctl.state == ST_LDIVI) dneg_ff <= mul_ff[PW-1];
            dn_ff     <= su_n;
            dsh_ff    <= su_dsh;
            q_ff      <= '0;
            dzero_ff  <= (su_mag == '0);
            dclamp_ff <= (su_den == '0) || (su_mag >= (DNW'(su_den) << 12));
         end
         ST_LDIV, ST_ADIV: begin
            if (div_ge) dn_ff <= dn_ff - DNW'(dsh_ff);
            q_ff   <= {q_ff[QW-2:0], div_ge};
            dsh_ff <= dsh_ff >> 1;
         end
         ST_AMUL: begin
            // speed command is the negated ratio
            rel_lin_ff <= dneg_ff ? relp : -relp;
            dneg_ff    <= adiff[ANG_W];
            mul_ff     <= prod;
         end
         ST_VLIN: begin
            rel_ang_ff <= dneg_ff ? -relp : relp;
            mul_ff     <= prod;
         end
         ST_VANG: begin
            lin_v_ff <= vsat[VEL_BITS-1:0];
            mul_ff   <= prod;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_lin_ff  <= lin_v_ff;
               rsp_ang_ff  <= vsat[VEL_BITS-1:0];
               rsp_stop_ff <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_linear_velocity  = rsp_lin_ff;
   assign rsp_angular_velocity = rsp_ang_ff;
   assign rsp_is_stop          = rsp_stop_ff;

   `MPV_ASSERT(a_stop_zero, clock, reset, rsp_valid_ff && rsp_stop_ff |-> rsp_lin_ff == 0 && rsp_ang_ff == 0, "stop command with nonzero velocity")
   `MPV_ASSERT(a_ref_drop, clock, reset, $fell(ref_valid_ff) |-> $past(ctl.state) == ST_MISS, "reference dropped outside a miss")
   `MPV_ASSERT(a_ref_set, clock, reset, ctl.state == ST_DECIDE && !ref_valid_ff |=> ref_valid_ff, "first sighting did not store a reference")

endmodule
`default_nettype wire

@@ tb/marker_pose_to_velocity_command_unit_tb.sv @@
// Self-checking testbench for the marker pose to velocity command unit
`default_nettype none
module marker_pose_to_velocity_command_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpv_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 160;

   typedef struct {
      logic signed [15:0] lin;
      logic signed [15:0] ang;
      logic               stop;
   } drive_cmd_type;

   class velocity_scoreboard;
      drive_cmd_type pending_cmds[$];
      int          errors;
      bit [31:0]   timeout_ms;
      bit [15:0]   speed_scale;
      bit [12:0]   max_angle;
      bit [14:0]   max_lin;
      bit [14:0]   max_ang;
      bit          have_ref;
      longint      ref_dist;
      longint      ref_angle;
      bit [31:0]   last_hit;

      function new();
         errors      = 0;
         timeout_ms  = TIMEOUT_RST;
         speed_scale = SPEED_SCALE_RST;
         max_angle   = MAX_ANGLE_RST;
         max_lin     = MAX_LIN_RST;
         max_ang     = MAX_ANGSTEP_RST;
         have_ref    = 0;
      endfunction

      function void write_reg(bit [2:0] idx, bit [31:0] val);
         case (idx)
            REG_TIMEOUT:     timeout_ms  = val;
            REG_SPEED_SCALE: speed_scale = val[15:0];
            REG_MAX_ANGLE:   max_angle   = val[12:0];
            REG_MAX_LIN:     max_lin     = val[14:0];
            REG_MAX_ANGSTEP: max_ang     = val[14:0];
            default: ;
         endcase
      endfunction

      function longint isqrt(longint unsigned n);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n  -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return longint'(res);
      endfunction

      function longint cordic_angle(longint y, longint x);
         longint z, t, xs, ys;
         z = 0;
         if (x == 0 && y == 0) return 0;
         x = x * 65536;
         y = y * 65536;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = HALF_PI_Q16;
            end else begin
               t = x; x = -y; y = t; z = -HALF_PI_Q16;
            end
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z += longint'(atan_entry(5'(i)));
            end else begin
               x = x - ys; y = y + xs; z -= longint'(atan_entry(5'(i)));
            end
         end
         return z;
      endfunction

      function longint ratio_q12(longint num, longint unsigned den);
         longint unsigned mag, q;
         mag = (num < 0) ? longint'(-num) : longint'(num);
         if (mag == 0) return 0;
         if (den == 0 || mag >= 4096 * den) q = 4096;
         else q = (2 * mag + den) / (2 * den);
         return (num < 0) ? -longint'(q) : longint'(q);
      endfunction

      function logic signed [15:0] scale_velocity(longint rel, bit [14:0] stepv);
         longint p, v;
         longint unsigned mag;
         p   = rel * longint'(stepv);
         mag = (p < 0) ? longint'(-p) : longint'(p);
         mag = (mag + 2048) >> 12;
         v   = (p < 0) ? -longint'(mag) : longint'(mag);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return 16'(v);
      endfunction

      function void note_frame(bit found, bit [7:0][15:0] c, bit [31:0] now);
         longint sx, sy, vx, vy, distance, ang, diff, mrad;
         longint unsigned dmag;
         drive_cmd_type cmd;
         if (!found) begin
            if (!have_ref) return;
            cmd.lin = 0; cmd.ang = 0; cmd.stop = 1;
            pending_cmds.push_back(cmd);
            if (32'(now - last_hit) > timeout_ms) have_ref = 0;
            return;
         end
         sx = longint'(c[0]) + longint'(c[2]) + longint'(c[4]) + longint'(c[6]);
         sy = longint'(c[1]) + longint'(c[3]) + longint'(c[5]) + longint'(c[7]);
         vx = 4 * longint'(c[0]) - sx;
         vy = 4 * longint'(c[1]) - sy;
         distance = isqrt(longint'(vx * vx + vy * vy) * 256);
         ang = cordic_angle(vy, vx);
         last_hit = now;
         if (!have_ref) begin
            have_ref  = 1;
            ref_dist  = distance;
            ref_angle = ang;
            return;
         end
         diff = ang - ref_angle;
         dmag = (diff < 0) ? longint'(-diff) : longint'(diff);
         dmag = (dmag * 1000 + 32768) >> 16;
         mrad = (diff < 0) ? -longint'(dmag) : longint'(dmag);
         cmd.lin = scale_velocity(-ratio_q12((distance - ref_dist) * longint'(speed_scale) * 16,
                                             ref_dist), max_lin);
         cmd.ang = scale_velocity(ratio_q12(mrad * 4096, max_angle), max_ang);
         cmd.stop = 0;
         pending_cmds.push_back(cmd);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, msg);
      endtask

      task check_cmd(logic signed [15:0] lin, logic signed [15:0] ang, logic stop);
         drive_cmd_type want;
         if (pending_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command lin=%0d ang=%0d stop=%0b",
                                      lin, ang, stop));
            return;
         end
         want = pending_cmds.pop_front();
         if (lin !== want.lin)
            report_mismatch($sformatf("linear %0d, want %0d", lin, want.lin));
         if (ang !== want.ang)
            report_mismatch($sformatf("angular %0d, want %0d", ang, want.ang));
         if (stop !== want.stop)
            report_mismatch($sformatf("is_stop %0b, want %0b", stop, want.stop));
      endtask
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_found = 0;
   logic [7:0][15:0]  req_corners = '0;
   logic [31:0]       req_time_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic signed [15:0] rsp_linear_velocity;
   logic signed [15:0] rsp_angular_velocity;
   logic              rsp_is_stop;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_data = '0;

   velocity_scoreboard sb = new();
   bit        idle_en = 1;
   int        hold_cycles = 0;
   bit [31:0] now_ms = 0;

   marker_pose_to_velocity_command_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_found(req_found),
      .req_corner0_x(req_corners[0]), .req_corner0_y(req_corners[1]),
      .req_corner1_x(req_corners[2]), .req_corner1_y(req_corners[3]),
      .req_corner2_x(req_corners[4]), .req_corner2_y(req_corners[5]),
      .req_corner3_x(req_corners[6]), .req_corner3_y(req_corners[7]),
      .req_time_ms(req_time_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_linear_velocity(rsp_linear_velocity),
      .rsp_angular_velocity(rsp_angular_velocity), .rsp_is_stop(rsp_is_stop),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8ns * 2_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stall bursts plus an optional long hold-off
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 0;
         end else if (burst > 0) begin
            burst--;
            rsp_ready <= 0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_cmd(rsp_linear_velocity, rsp_angular_velocity, rsp_is_stop);
   end

   task automatic send_frame(bit found, bit [7:0][15:0] c, bit [31:0] t);
      req_valid   <= 1;
      req_found   <= found;
      req_corners <= c;
      req_time_ms <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(found, c, t);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(bit [2:0] idx, bit [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic bit [7:0][15:0] square(bit [15:0] cx, bit [15:0] cy,
                                             bit [15:0] dx, bit [15:0] dy);
      bit [7:0][15:0] c;
      c[0] = cx + dx; c[1] = cy + dy;
      c[2] = cx - dy; c[3] = cy + dx;
      c[4] = cx - dx; c[5] = cy - dy;
      c[6] = cx + dy; c[7] = cy - dx;
      return c;
   endfunction

   function automatic bit [7:0][15:0] noise_corners();
      bit [7:0][15:0] c;
      for (int i = 0; i < 8; i++) c[i] = $urandom;
      return c;
   endfunction

   // tracks of plausible marker motion, with misses, timeouts and noise frames
   task automatic random_frames(int count);
      bit [15:0] cx, cy, dx, dy;
      int n;
      n = 0;
      while (n < count) begin
         cx = $urandom_range(4000, 60000);
         cy = $urandom_range(4000, 60000);
         dx = $urandom_range(0, 2000) - 1000;
         dy = $urandom_range(0, 2000) - 1000;
         if ($urandom_range(0, 9) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
         repeat ($urandom_range(3, 20)) begin
            case ($urandom_range(0, 19))
               0, 1: send_frame(0, noise_corners(), now_ms);
               2:    send_frame($urandom, noise_corners(), $urandom);
               3: begin
                  now_ms += $urandom_range(0, 12000);
                  send_frame(0, noise_corners(), now_ms);
               end
               default: begin
                  dx += $urandom_range(0, 80) - 40;
                  dy += $urandom_range(0, 80) - 40;
                  cx += $urandom_range(0, 200) - 100;
                  send_frame(1, square(cx, cy, dx, dy), now_ms);
               end
            endcase
            now_ms += $urandom_range(10, 120);
            n++;
         end
      end
   endtask

   initial begin
      bit [7:0][15:0] c;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: miss without reference, zero-distance reference, extremes
      send_frame(0, '0, 32'd0);
      send_frame(1, '0, 32'd10);
      c = '0; c[0] = 16'hFFFF; c[1] = 16'hFFFF;
      send_frame(1, c, 32'd20);
      send_frame(1, {8{16'hFFFF}}, 32'd30);
      send_frame(0, '0, 32'd5030);
      send_frame(0, '0, 32'd5031);
      send_frame(0, '0, 32'd5032);
      send_frame(1, square(16'd30000, 16'd30000, 16'd800, 16'd0), 32'hFFFF_FF00);
      send_frame(1, square(16'd30000, 16'd30000, 16'd0, 16'd800), 32'hFFFF_FF10);
      send_frame(1, square(16'd30000, 16'd30000, -16'd800, 16'd0), 32'hFFFF_FF20);
      send_frame(1, square(16'd30000, 16'd30000, 16'd0, -16'd800), 32'hFFFF_FF30);
      send_frame(1, square(16'd30000, 16'd30000, -16'd800, -16'd1), 32'hFFFF_FF40);
      send_frame(1, square(16'd30000, 16'd30000, 16'd1600, 16'd0), 32'hFFFF_FF50);
      send_frame(1, square(16'd30000, 16'd30000, 16'd400, 16'd0), 32'hFFFF_FF60);
      send_frame(0, '0, 32'd100);
      send_frame(0, '0, 32'd5000);
      send_frame(1, c, 32'd6000);
      send_frame(1, '0, 32'd6001);
      drain();

      // extreme settings, out-of-width bits and an unused index
      write_csr(REG_TIMEOUT, 32'd0);
      write_csr(REG_SPEED_SCALE, 32'hFFFF_FFFF);
      write_csr(REG_MAX_ANGLE, 32'hFFFF_E001);
      write_csr(REG_MAX_LIN, 32'hFFFF_FFFF);
      write_csr(REG_MAX_ANGSTEP, 32'h0001_7FFF);
      write_csr(REG_UNUSED, $urandom);
      random_frames(220);
      drain();

      write_csr(REG_TIMEOUT, 32'hFFFF_FFFF);
      write_csr(REG_SPEED_SCALE, 32'd0);
      write_csr(REG_MAX_ANGLE, 32'd6283);
      write_csr(REG_MAX_LIN, 32'd0);
      write_csr(REG_MAX_ANGSTEP, 32'd0);
      random_frames(220);
      drain();

      // long receiver hold-off while frames keep coming
      write_csr(REG_TIMEOUT, TIMEOUT_RST);
      write_csr(REG_SPEED_SCALE, SPEED_SCALE_RST);
      write_csr(REG_MAX_ANGLE, MAX_ANGLE_RST);
      write_csr(REG_MAX_LIN, MAX_LIN_RST);
      write_csr(REG_MAX_ANGSTEP, MAX_ANGSTEP_RST);
      hold_cycles = 600;
      random_frames(220);
      drain();

      repeat (2) begin
         write_csr(REG_TIMEOUT, $urandom_range(0, 20000));
         write_csr(REG_SPEED_SCALE, $urandom);
         write_csr(REG_MAX_ANGLE, $urandom_range(1, 6283));
         write_csr(REG_MAX_LIN, $urandom);
         write_csr(REG_MAX_ANGSTEP, $urandom);
         random_frames(220);
         drain();
      end

      idle_en = 0;
      write_csr(REG_SPEED_SCALE, $urandom_range(0, 4096));
      write_csr(REG_MAX_ANGLE, $urandom_range(1, 500));
      random_frames(220);
      drain();

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
